// ===== sv/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, codes and helpers for the ground snap probe.
// ----------------------------------------------------------------------------
package gsp_pkg;

    // Command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Shape codes (the unused code behaves as a box)
    localparam logic [1:0] SHAPE_BOX     = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE  = 2'd1;
    localparam logic [1:0] SHAPE_CAPSULE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_STEP_HEIGHT   = 2'd0;
    localparam logic [1:0] REG_SNAP_DISTANCE = 2'd1;
    localparam logic [1:0] REG_SKIN_WIDTH    = 2'd2;

    // Register reset values (Q16.16)
    localparam logic [30:0] RST_STEP_HEIGHT   = 31'd19661;
    localparam logic [30:0] RST_SNAP_DISTANCE = 31'd6554;
    localparam logic [30:0] RST_SKIN_WIDTH    = 31'd655;

    // Default table depth
    localparam int MAX_GROUNDS_DEF = 256;

    // Saturation bounds in the wide working format
    localparam logic signed [33:0] S34_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S34_MIN = -34'sd2147483648;

    // One stored ground collider
    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] top;
        logic signed [31:0] cx;
        logic signed [31:0] cz;
        logic [30:0]        hx;
        logic [30:0]        hz;
    } t_entry;

    // Body under query plus the gap window
    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] bottom;
        logic signed [31:0] cx;
        logic signed [31:0] cz;
        logic [30:0]        hx;
        logic [30:0]        hz;
        logic [30:0]        step_height;
        logic [30:0]        snap_distance;
    } t_query;

    // Verdict of the compare unit for one entry
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic signed [31:0] top;
        logic [15:0]        id;
    } t_hit;

    function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic signed [33:0] zx34(input logic [30:0] v);
        return {3'b000, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > S34_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S34_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/gsp_table.sv =====
// ----------------------------------------------------------------------------
// gsp_table
// Ground collider store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gsp_table #(
    parameter int DEPTH = gsp_pkg::MAX_GROUNDS_DEF,
    parameter int AW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  gsp_pkg::t_entry      i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output gsp_pkg::t_entry      o_rdata
);

    gsp_pkg::t_entry r_mem [DEPTH];
    gsp_pkg::t_entry r_rdata;

    // Store one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gsp_eval.sv =====
// ----------------------------------------------------------------------------
// gsp_eval
// Compare unit: tests one stored ground against the queried body per cycle.
// ----------------------------------------------------------------------------
module gsp_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  gsp_pkg::t_entry   i_entry,
    input  gsp_pkg::t_query   i_query,
    output gsp_pkg::t_hit     o_hit
);

    logic signed [33:0] dx;
    logic signed [33:0] dz;
    logic signed [33:0] adx;
    logic signed [33:0] adz;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_z;
    logic signed [33:0] gap;
    logic               ov_x;
    logic               ov_z;
    logic               in_win;
    logic               hit;
    logic               r_vld;
    logic               r_hit;
    logic signed [31:0] r_top;
    logic [15:0]        r_id;

    // Check XZ overlap and the vertical gap window, skipping the body's own id
    always_comb begin
        dx     = gsp_pkg::sx34(i_query.cx) - gsp_pkg::sx34(i_entry.cx);
        dz     = gsp_pkg::sx34(i_query.cz) - gsp_pkg::sx34(i_entry.cz);
        adx    = (dx < 0) ? -dx : dx;
        adz    = (dz < 0) ? -dz : dz;
        sum_x  = gsp_pkg::zx34(i_query.hx) + gsp_pkg::zx34(i_entry.hx);
        sum_z  = gsp_pkg::zx34(i_query.hz) + gsp_pkg::zx34(i_entry.hz);
        ov_x   = (adx <= sum_x);
        ov_z   = (adz <= sum_z);
        gap    = gsp_pkg::sx34(i_query.bottom) - gsp_pkg::sx34(i_entry.top);
        in_win = (gap >= -gsp_pkg::zx34(i_query.step_height)) &&
                 (gap <= gsp_pkg::zx34(i_query.snap_distance));
        hit    = (i_entry.id != i_query.id) && ov_x && ov_z && in_win;
    end

    // Register the verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= hit;
        r_top <= i_entry.top;
        r_id  <= i_entry.id;
    end

    assign o_hit = '{vld: r_vld, hit: r_hit, top: r_top, id: r_id};

endmodule

// ===== sv/ground_snap_probe_core.sv =====
// ----------------------------------------------------------------------------
// ground_snap_probe_core
// Ground snapping probe over a table of static colliders.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the item fields with start; a transaction is taken
//   at a rising edge where start is high and busy is low. cmd 0 clears the
//   table, cmd 1 loads one ground, cmd 2 queries one body, cmd 3 does nothing.
//   Every transaction gives exactly one result on o_status, o_ground_id and
//   o_correction, marked by o_result_valid for one cycle; busy drops in the
//   same cycle, so the next transaction may be taken at that edge.
//   Sequence: clear, load and no-op run the EDGE1 and EDGE2 steps of the
//   shared saturating height adder, then give the result strobe. A query runs
//   the same steps, then scans the stored grounds: the compare unit
//   sees one table entry per cycle through the single read port, then the
//   pipe drains.
//   Configuration: APB writes to step_height (0x0), snap_distance (0x4) and
//   skin_width (0x8) while idle; pready is always high, reads return values.
//   Reset empties the table, restores register defaults and goes idle. The
//   receiver cannot stall; results must be taken in their strobe cycle.
// ----------------------------------------------------------------------------
module ground_snap_probe_core #(
    parameter int MAX_GROUNDS = gsp_pkg::MAX_GROUNDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_entity_id,
    input  logic [1:0]         i_shape,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic [30:0]        i_half_x,
    input  logic [30:0]        i_half_y,
    input  logic [30:0]        i_half_z,
    input  logic [30:0]        i_radius,
    input  logic [30:0]        i_capsule_half,
    // result channel
    output logic               o_result_valid,
    output logic [1:0]         o_status,
    output logic [15:0]        o_ground_id,
    output logic signed [31:0] o_correction,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (MAX_GROUNDS > 1) ? $clog2(MAX_GROUNDS) : 1;
    localparam int CW = $clog2(MAX_GROUNDS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EDGE1 = 5'b00010,
        S_EDGE2 = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DRAIN = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;

    logic [30:0]        r_step;
    logic [30:0]        r_snap;
    logic [30:0]        r_skin;

    logic [1:0]         r_cmd;
    logic [15:0]        r_id;
    logic [1:0]         r_shape;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cz;
    logic signed [31:0] r_y;
    logic [30:0]        r_hx;
    logic [30:0]        r_hz;
    logic [30:0]        r_half_y;
    logic [30:0]        r_radius;
    logic [30:0]        r_caps;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_rd_vld;
    logic               r_found;
    logic signed [31:0] r_best_top;
    logic [15:0]        r_best_id;

    logic               r_res_vld;
    logic [1:0]         r_status;
    logic [15:0]        r_gid;
    logic signed [31:0] r_corr;

    logic               accept;
    logic               cfg_wr;
    logic [30:0]        edge_op;
    logic signed [33:0] edge_sum;
    logic signed [31:0] edge_y;
    logic               is_capsule;
    logic               is_sphere;
    logic               issue;
    logic               table_full;
    logic               drain_done;
    logic               take_best;
    logic signed [31:0] corr_sat;
    logic               tbl_we;
    gsp_pkg::t_entry    tbl_wdata;
    gsp_pkg::t_entry    tbl_rdata;
    gsp_pkg::t_query    query;
    gsp_pkg::t_hit      hit;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= gsp_pkg::RST_STEP_HEIGHT;
            r_snap <= gsp_pkg::RST_SNAP_DISTANCE;
            r_skin <= gsp_pkg::RST_SKIN_WIDTH;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                gsp_pkg::REG_STEP_HEIGHT:   r_step <= pwdata[30:0];
                gsp_pkg::REG_SNAP_DISTANCE: r_snap <= pwdata[30:0];
                gsp_pkg::REG_SKIN_WIDTH:    r_skin <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (paddr[3:2])
            gsp_pkg::REG_STEP_HEIGHT:   prdata = {1'b0, r_step};
            gsp_pkg::REG_SNAP_DISTANCE: prdata = {1'b0, r_snap};
            gsp_pkg::REG_SKIN_WIDTH:    prdata = {1'b0, r_skin};
            default:                    prdata = '0;
        endcase
    end

    // Shared saturating height adder: upward for a load, downward for every other command
    always_comb begin
        is_capsule = (r_shape == gsp_pkg::SHAPE_CAPSULE);
        is_sphere  = (r_shape == gsp_pkg::SHAPE_SPHERE);
        if (r_state == S_EDGE1) begin
            edge_op = is_capsule ? r_caps : (is_sphere ? r_radius : r_half_y);
        end else begin
            edge_op = is_capsule ? r_radius : '0;
        end
        if (r_cmd == gsp_pkg::CMD_LOAD) begin
            edge_sum = gsp_pkg::sx34(r_y) + gsp_pkg::zx34(edge_op);
        end else begin
            edge_sum = gsp_pkg::sx34(r_y) - gsp_pkg::zx34(edge_op);
        end
        edge_y = gsp_pkg::sat32(edge_sum);
    end

    assign table_full = (r_count >= CW'(MAX_GROUNDS));
    assign issue      = (r_state == S_SCAN) && (r_idx < r_count);
    assign drain_done = !r_rd_vld && !hit.vld;
    assign take_best  = hit.vld && hit.hit && (!r_found || (hit.top > r_best_top));
    assign corr_sat   = gsp_pkg::sat32(gsp_pkg::sx34(r_best_top) - gsp_pkg::sx34(r_y) +
                                       gsp_pkg::zx34(r_skin));

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_EDGE1;
            S_EDGE1: n_state = S_EDGE2;
            S_EDGE2: n_state = (r_cmd == gsp_pkg::CMD_QUERY) ? S_SCAN : S_IDLE;
            S_SCAN:  if (!issue) n_state = S_DRAIN;
            S_DRAIN: if (drain_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_cmd;
            r_id     <= i_entity_id;
            r_shape  <= i_shape;
            r_cx     <= i_center_x;
            r_cz     <= i_center_z;
            r_half_y <= i_half_y;
            r_radius <= i_radius;
            r_caps   <= i_capsule_half;
            if ((i_shape == gsp_pkg::SHAPE_SPHERE) || (i_shape == gsp_pkg::SHAPE_CAPSULE)) begin
                r_hx <= i_radius;
                r_hz <= i_radius;
            end else begin
                r_hx <= i_half_x;
                r_hz <= i_half_z;
            end
        end
    end

    // Running height: center, then each saturating step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_y <= i_center_y;
        end else if ((r_state == S_EDGE1) || (r_state == S_EDGE2)) begin
            r_y <= edge_y;
        end
    end

    // Table fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == S_EDGE2) begin
            if (r_cmd == gsp_pkg::CMD_CLEAR) begin
                r_count <= '0;
            end else if ((r_cmd == gsp_pkg::CMD_LOAD) && !table_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Table write on a load that fits
    assign tbl_we    = (r_state == S_EDGE2) && (r_cmd == gsp_pkg::CMD_LOAD) && !table_full;
    assign tbl_wdata = '{id: r_id, top: edge_y, cx: r_cx, cz: r_cz, hx: r_hx, hz: r_hz};

    // Scan index and read pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (r_state == S_EDGE2) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Keep the highest qualifying top; the earlier entry holds a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (r_state == S_EDGE2) begin
            r_found <= 1'b0;
        end else if (take_best) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_best) begin
            r_best_top <= hit.top;
            r_best_id  <= hit.id;
        end
    end

    assign query = '{
        id:            r_id,
        bottom:        r_y,
        cx:            r_cx,
        cz:            r_cz,
        hx:            r_hx,
        hz:            r_hz,
        step_height:   r_step,
        snap_distance: r_snap
    };

    gsp_table #(
        .DEPTH (MAX_GROUNDS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (tbl_wdata),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (tbl_rdata)
    );

    gsp_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_entry (tbl_rdata),
        .i_query (query),
        .o_hit   (hit)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= ((r_state == S_EDGE2) && (r_cmd != gsp_pkg::CMD_QUERY)) ||
                         ((r_state == S_DRAIN) && drain_done);
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_EDGE2) begin
            r_gid  <= '0;
            r_corr <= '0;
            if ((r_cmd == gsp_pkg::CMD_LOAD) && table_full) begin
                r_status <= gsp_pkg::ST_FULL;
            end else begin
                r_status <= gsp_pkg::ST_DONE;
            end
        end else if (r_state == S_DRAIN) begin
            if (r_found) begin
                r_status <= gsp_pkg::ST_FOUND;
                r_gid    <= r_best_id;
                r_corr   <= corr_sat;
            end else begin
                r_status <= gsp_pkg::ST_NONE;
                r_gid    <= '0;
                r_corr   <= '0;
            end
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_status       = r_status;
    assign o_ground_id    = r_gid;
    assign o_correction   = r_corr;

endmodule

// ===== sv/gsp_checker.sv =====
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks on the probe's command and result channels.
// ----------------------------------------------------------------------------
module gsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_valid,
    input logic [1:0]         o_status,
    input logic [15:0]        o_ground_id,
    input logic signed [31:0] o_correction
);

    // An accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // A result appears whenever busy drops
    a_result_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy fell without a result");

    // The result strobe never shows while still busy
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result while busy");

    // One result per transaction: never two strobes back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe repeated");

    // Only a found ground carries an id and a correction
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != gsp_pkg::ST_FOUND)) |->
            ((o_ground_id == 16'd0) && (o_correction == 32'sd0)))
        else $error("nonzero fields without a found ground");

endmodule

bind ground_snap_probe_core gsp_checker u_gsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_ground_id    (o_ground_id),
    .o_correction   (o_correction)
);
